FILE: design/ldd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_pkg
// Shared types, constants and symbol decode functions for the DEFLATE
// length/distance decoder.
// ----------------------------------------------------------------------------
package ldd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [8:0] EOB_SYMBOL     = 9'd256;
	localparam logic [8:0] LEN_SYM_FIRST  = 9'd257;
	localparam logic [8:0] LEN_SYM_LAST   = 9'd285;
	localparam logic [8:0] DIST_SYM_COUNT = 9'd30;
	localparam logic [8:0] MAX_MATCH_LEN  = 9'd258;
	localparam logic [15:0] MAX_MATCH_DIST = 16'd32768;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_MATCH   = 2'd1,
		KIND_EOB     = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TOK_LIT,
		TOK_EOB,
		TOK_LEN,
		TOK_BAD_LEN,
		TOK_DIST,
		TOK_BAD_DIST
	} tok_t;

	// classified symbol: literal byte, match length or distance in value
	typedef struct packed {
		tok_t        tok;
		logic [15:0] value;
	} token_t;

	// s is the length code minus 257, 0..28
	function automatic logic [8:0] len_value(input logic [4:0] s, input logic [12:0] extra);
		logic [2:0] e;
		logic [8:0] base;
		logic [8:0] mask;
		begin
			e    = s[4:2] - 3'd1;
			base = (9'({1'b1, s[1:0]}) << e) + 9'd3;
			mask = (9'd1 << e) - 9'd1;
			if (s < 5'd8) begin
				len_value = 9'(s) + 9'd3;
			end else if (s >= 5'd28) begin
				len_value = MAX_MATCH_LEN;
			end else begin
				len_value = base + (extra[8:0] & mask);
			end
		end
	endfunction

	// sym is a distance code, 0..29
	function automatic logic [15:0] dist_value(input logic [4:0] sym, input logic [12:0] extra);
		logic [3:0]  e;
		logic [15:0] base;
		logic [15:0] mask;
		begin
			e    = sym[4:1] - 4'd1;
			base = (16'({1'b1, sym[0]}) << e) + 16'd1;
			mask = (16'd1 << e) - 16'd1;
			if (sym < 5'd4) begin
				dist_value = 16'(sym) + 16'd1;
			end else begin
				dist_value = base + (16'(extra) & mask);
			end
		end
	endfunction

endpackage

FILE: design/ldd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_front
// Classifies an incoming symbol and works out its literal, length or
// distance value, independent of decoder state.
// ----------------------------------------------------------------------------
module ldd_front
	import ldd_pkg::*;
(
	input  logic        command,
	input  logic [8:0]  symbol,
	input  logic [12:0] extra_bits,
	output token_t      token
);

	always_comb begin
		token.tok   = TOK_BAD_LEN;
		token.value = '0;
		if (!command) begin
			if (symbol < EOB_SYMBOL) begin
				token.tok   = TOK_LIT;
				token.value = 16'(symbol[7:0]);
			end else if (symbol == EOB_SYMBOL) begin
				token.tok = TOK_EOB;
			end else if (symbol <= LEN_SYM_LAST) begin
				token.tok   = TOK_LEN;
				token.value = 16'(len_value(5'(symbol - LEN_SYM_FIRST), extra_bits));
			end else begin
				token.tok = TOK_BAD_LEN;
			end
		end else begin
			if (symbol < DIST_SYM_COUNT) begin
				token.tok   = TOK_DIST;
				token.value = dist_value(symbol[4:0], extra_bits);
			end else begin
				token.tok = TOK_BAD_DIST;
			end
		end
	end

endmodule

FILE: design/ldd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_queue
// Small token queue between the classifier and the state machine side.
// ----------------------------------------------------------------------------
module ldd_queue
	import ldd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  token_t wr_data,
	input  logic   rd_en,
	output token_t rd_data,
	output logic   full,
	output logic   nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	token_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CNT_FULL);
	assign nonempty = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: design/ldd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_back
// Tracks the pending match length and turns tokens into result items,
// held in an output register until popped.
// ----------------------------------------------------------------------------
module ldd_back
	import ldd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  token_t      tok,
	output logic        tok_take,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  kind,
	output logic [7:0]  literal,
	output logic [8:0]  match_length,
	output logic [15:0] match_distance
);

	logic        awaiting_q;
	logic [8:0]  pending_q;
	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  literal_q;
	logic [8:0]  length_q;
	logic [15:0] distance_q;

	logic        emits;
	logic        out_free;
	kind_t       kind_d;
	logic [7:0]  literal_d;
	logic [8:0]  length_d;
	logic [15:0] distance_d;
	logic        awaiting_d;
	logic [8:0]  pending_d;

	always_comb begin
		emits      = 1'b1;
		kind_d     = KIND_ERROR;
		literal_d  = '0;
		length_d   = '0;
		distance_d = '0;
		awaiting_d = awaiting_q;
		pending_d  = pending_q;
		unique case (tok.tok)
			TOK_LIT, TOK_EOB, TOK_LEN, TOK_BAD_LEN: begin
				if (awaiting_q) begin
					// literal/length symbol where a distance was due
					awaiting_d = 1'b0;
					pending_d  = '0;
				end else if (tok.tok == TOK_LIT) begin
					kind_d    = KIND_LITERAL;
					literal_d = tok.value[7:0];
				end else if (tok.tok == TOK_EOB) begin
					kind_d = KIND_EOB;
				end else if (tok.tok == TOK_LEN) begin
					emits      = 1'b0;
					awaiting_d = 1'b1;
					pending_d  = tok.value[8:0];
				end
			end
			TOK_DIST, TOK_BAD_DIST: begin
				if (awaiting_q) begin
					awaiting_d = 1'b0;
					pending_d  = '0;
					if (tok.tok == TOK_DIST) begin
						kind_d     = KIND_MATCH;
						length_d   = pending_q;
						distance_d = tok.value;
					end
				end
			end
			default: begin
				kind_d = KIND_ERROR;
			end
		endcase
	end

	assign out_free = !out_valid_q || pop;
	assign tok_take = tok_valid && (out_free || !emits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_take) begin
				awaiting_q <= awaiting_d;
				pending_q  <= pending_d;
			end
			if (tok_take && emits) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take && emits) begin
			kind_q     <= kind_d;
			literal_q  <= literal_d;
			length_q   <= length_d;
			distance_q <= distance_d;
		end
	end

	assign empty          = !out_valid_q;
	assign kind           = kind_q;
	assign literal        = literal_q;
	assign match_length   = length_q;
	assign match_distance = distance_q;

endmodule

FILE: design/deflate_length_distance_decoder.sv
`timescale 1ns / 1ps
// a result passes through the token queue and then the output register before it shows on the output ports
// throughput: one symbol per cycle unless an unpopped output stalls ldd_back, set by the state update in ldd_back
// a stalled output fills the token queue (QDEPTH entries, QUEUE_DEPTH by default) before full rises
// reset (arst_n low) empties queue and output and clears the pending length
// ----------------------------------------------------------------------------
// deflate_length_distance_decoder
// Turns Huffman-decoded DEFLATE symbols plus extra bits into literal,
// match, end-of-block and error tokens.
// ----------------------------------------------------------------------------
module deflate_length_distance_decoder
	import ldd_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [8:0]  symbol,
	input  logic [12:0] extra_bits,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  literal,
	output logic [8:0]  match_length,
	output logic [15:0] match_distance
);

	token_t front_tok;
	token_t queue_tok;
	logic   queue_nonempty;
	logic   queue_take;

	ldd_front u_front (
		.command    (command),
		.symbol     (symbol),
		.extra_bits (extra_bits),
		.token      (front_tok)
	);

	ldd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push && !full),
		.wr_data  (front_tok),
		.rd_en    (queue_take),
		.rd_data  (queue_tok),
		.full     (full),
		.nonempty (queue_nonempty)
	);

	ldd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_valid      (queue_nonempty),
		.tok            (queue_tok),
		.tok_take       (queue_take),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.literal        (literal),
		.match_length   (match_length),
		.match_distance (match_distance)
	);

`ifndef SYNTHESIS
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ERROR) |->
		(literal == '0 && match_length == '0 && match_distance == '0))
		else $error("error token with nonzero payload");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_MATCH) |->
		(match_length >= 9'd3 && match_length <= MAX_MATCH_LEN &&
		 match_distance != '0 && match_distance <= MAX_MATCH_DIST && literal == '0))
		else $error("match token out of range");

	a_literal_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_LITERAL && kind != KIND_MATCH) |->
		(literal == '0 && match_length == '0))
		else $error("payload set on non-literal token");
`endif

endmodule

FILE: test/tb_deflate_length_distance_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deflate_length_distance_decoder
// Feeds literal/length and distance symbols through the push/full port and
// checks every token taken from the empty/pop port against a local decoder
// model. Runs directed corner symbols and then random symbol streams, mostly
// well-formed length/distance pairs, under several sender and receiver idle
// patterns, including one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_deflate_length_distance_decoder;
	import ldd_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 480;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic        cmd;
		logic [8:0]  sym;
		logic [12:0] extra;
	} sym_item_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  lit;
		logic [8:0]  len;
		logic [15:0] distance;
	} dec_token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        command = 1'b0;
	logic [8:0]  symbol = 9'd0;
	logic [12:0] extra_bits = 13'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  literal;
	logic [8:0]  match_length;
	logic [15:0] match_distance;

	sym_item_t  symbol_queue[$];
	dec_token_t expected_tokens[$];

	// decoder state mirrored from the block
	logic [8:0] held_len = 9'd0;
	logic       awaiting_dist = 1'b0;

	int send_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int err_cnt = 0;
	int quiet_cycles = 0;

	deflate_length_distance_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.symbol         (symbol),
		.extra_bits     (extra_bits),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.literal        (literal),
		.match_length   (match_length),
		.match_distance (match_distance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// returns 1 when the symbol yields a token
	function automatic bit decode_symbol(input logic cmd, input logic [8:0] sym,
			input logic [12:0] extra, output dec_token_t tok);
		int s;
		int e;
		int len_val;
		int dist_val;
		tok = '{KIND_ERROR, 8'd0, 9'd0, 16'd0};
		if (!cmd) begin
			// a literal/length symbol where a distance was due
			if (awaiting_dist) begin
				awaiting_dist = 1'b0;
				held_len = 9'd0;
				return 1'b1;
			end
			if (sym < EOB_SYMBOL) begin
				tok.kind = KIND_LITERAL;
				tok.lit = sym[7:0];
				return 1'b1;
			end
			if (sym == EOB_SYMBOL) begin
				tok.kind = KIND_EOB;
				return 1'b1;
			end
			if (sym <= LEN_SYM_LAST) begin
				s = sym - LEN_SYM_FIRST;
				if (s < 8) begin
					len_val = s + 3;
				end else if (s >= 28) begin
					len_val = MAX_MATCH_LEN;
				end else begin
					e = (s >> 2) - 1;
					len_val = ((4 + (s & 3)) << e) + 3 + (extra & ((1 << e) - 1));
				end
				held_len = len_val[8:0];
				awaiting_dist = 1'b1;
				return 1'b0;
			end
			return 1'b1;
		end
		if (!awaiting_dist)
			return 1'b1;
		awaiting_dist = 1'b0;
		if (sym >= DIST_SYM_COUNT) begin
			held_len = 9'd0;
			return 1'b1;
		end
		if (sym < 4) begin
			dist_val = sym + 1;
		end else begin
			e = (sym >> 1) - 1;
			dist_val = ((2 + (sym & 1)) << e) + 1 + (extra & ((1 << e) - 1));
		end
		tok.kind = KIND_MATCH;
		tok.len = held_len;
		tok.distance = dist_val[15:0];
		held_len = 9'd0;
		return 1'b1;
	endfunction

	// symbol driver: the head of symbol_queue is offered until its transfer
	always @(posedge clk) begin
		dec_token_t tok;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				if (decode_symbol(command, symbol, extra_bits, tok))
					expected_tokens.push_back(tok);
				void'(symbol_queue.pop_front());
			end
			if (!(push && full)) begin
				if (symbol_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					command <= symbol_queue[0].cmd;
					symbol <= symbol_queue[0].sym;
					extra_bits <= symbol_queue[0].extra;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// token monitor and receiver stalls
	always @(posedge clk) begin
		dec_token_t want;
		if (pop && !empty) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d", kind);
				err_cnt++;
			end else begin
				want = expected_tokens.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					err_cnt++;
				end
				if (literal !== want.lit) begin
					$error("literal: expected %0d, got %0d", want.lit, literal);
					err_cnt++;
				end
				if (match_length !== want.len) begin
					$error("match_length: expected %0d, got %0d", want.len, match_length);
					err_cnt++;
				end
				if (match_distance !== want.distance) begin
					$error("match_distance: expected %0d, got %0d", want.distance,
						match_distance);
					err_cnt++;
				end
			end
		end
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		pop <= arst_n && hold_ack == hold_req && hold_left == 0 &&
			$urandom_range(99) >= rx_stall_pct;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_deflate_length_distance_decoder: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic add_sym(input logic cmd, input int sym, input int extra);
		symbol_queue.push_back('{cmd, sym[8:0], extra[12:0]});
	endtask

	task automatic add_random(input int count);
		int n;
		int pick;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			if (pick < 38) begin
				add_sym(1'b0, $urandom_range(255), $urandom_range(8191));
				n += 1;
			end else if (pick < 43) begin
				add_sym(1'b0, EOB_SYMBOL, $urandom_range(8191));
				n += 1;
			end else if (pick < 85) begin
				add_sym(1'b0, $urandom_range(LEN_SYM_LAST, LEN_SYM_FIRST),
					$urandom_range(8191));
				add_sym(1'b1, $urandom_range(DIST_SYM_COUNT - 1), $urandom_range(8191));
				n += 2;
			end else begin
				// noise: either kind, symbols mostly drawn from 0..287
				add_sym(1'($urandom_range(1)),
					($urandom_range(9) < 7) ? $urandom_range(287) : $urandom_range(511),
					$urandom_range(8191));
				n += 1;
			end
		end
	endtask

	task automatic wait_drained();
		while (symbol_queue.size() != 0 || expected_tokens.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner symbols
		add_sym(1'b0, 0, 8191);
		add_sym(1'b0, 255, 0);
		add_sym(1'b0, EOB_SYMBOL, 0);
		add_sym(1'b0, 257, 0);
		add_sym(1'b1, 0, 0);
		add_sym(1'b0, 264, 8191);
		add_sym(1'b1, 3, 8191);
		add_sym(1'b0, 265, 8191);
		add_sym(1'b1, 4, 1);
		add_sym(1'b0, 284, 8191);
		add_sym(1'b1, 29, 8191);
		add_sym(1'b0, 285, 0);
		add_sym(1'b1, 28, 0);
		add_sym(1'b0, 286, 0);
		add_sym(1'b0, 287, 8191);
		// distance with no length before it
		add_sym(1'b1, 5, 3);
		// literal where a distance was due, then the stray distance
		add_sym(1'b0, 270, 5);
		add_sym(1'b0, 65, 0);
		add_sym(1'b1, 2, 0);
		// distance codes out of range
		add_sym(1'b0, 260, 0);
		add_sym(1'b1, 30, 0);
		add_sym(1'b0, 261, 0);
		add_sym(1'b1, 511, 8191);
		add_sym(1'b0, 511, 0);

		// no idling, with one long receiver hold-off
		send_idle_pct = 0;
		rx_stall_pct = 0;
		add_random(PHASE_ITEMS);
		hold_req++;
		wait_drained();

		send_idle_pct = 78;
		rx_stall_pct = 0;
		add_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		rx_stall_pct = 78;
		add_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 36;
		rx_stall_pct = 36;
		add_random(PHASE_ITEMS);
		wait_drained();

		// keep popping so a stray token would still be caught
		rx_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_deflate_length_distance_decoder: clean");
		else
			$display("tb_deflate_length_distance_decoder: errors");
		$finish;
	end

endmodule
